/* rtl/core/iba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bound accumulator package
// Shared types, codes and helpers for the instance bound accumulator.
// ----------------------------------------------------------------------------
package iba_pkg;

    // Fraction bits of the Q16.16 format.
    localparam int unsigned Q_FRAC = 16;

    // Axis codes carried by a word.
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_SIZE_X   = 3'd3;
    localparam logic [2:0] REG_SIZE_Y   = 3'd4;
    localparam logic [2:0] REG_SIZE_Z   = 3'd5;

    // Saturation limits of a Q16.16 value.
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Mesh bound settings seen by the datapath.
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        size_x;
        logic [30:0]        size_y;
        logic [30:0]        size_z;
    } mesh_cfg_t;

    // One classified interval waiting for the merge.
    typedef struct packed {
        logic [1:0]         axis;
        logic               first;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } span_t;

    // Clamp a 51-bit signed value into the Q16.16 range.
    function automatic logic signed [31:0] sat_q(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (!v[50] && (|v[49:31])) begin
            r = Q_MAX;
        end
        else if (v[50] && !(&v[49:31])) begin
            r = Q_MIN;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/iba_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bound accumulator channels
// Valid/ready channels for matrix rows in and updated bounds out.
// ----------------------------------------------------------------------------
interface iba_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         axis;
    logic               first;
    logic signed [31:0] row_x;
    logic signed [31:0] row_y;
    logic signed [31:0] row_z;
    logic signed [31:0] row_t;

    modport source (output valid, axis, first, row_x, row_y, row_z, row_t,
                    input ready);
    modport sink (input valid, axis, first, row_x, row_y, row_z, row_t,
                  output ready);
endinterface

interface iba_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         out_axis;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;

    modport source (output valid, out_axis, low_bound, high_bound,
                    input ready);
    modport sink (input valid, out_axis, low_bound, high_bound,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/iba_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bound accumulator registers
// APB-style register file holding the mesh bound centre and size.
// ----------------------------------------------------------------------------
module iba_regs
    import iba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output mesh_cfg_t        cfg
);

    mesh_cfg_t  cfg_reg;
    mesh_cfg_t  cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_CENTER_X: cfg_next.center_x = pwdata;
                REG_CENTER_Y: cfg_next.center_y = pwdata;
                REG_CENTER_Z: cfg_next.center_z = pwdata;
                REG_SIZE_X:   cfg_next.size_x   = pwdata[30:0];
                REG_SIZE_Y:   cfg_next.size_y   = pwdata[30:0];
                REG_SIZE_Z:   cfg_next.size_z   = pwdata[30:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux; the size registers read back zero-extended.
    always_comb
    begin
        unique case (reg_idx)
            REG_CENTER_X: prdata = cfg_reg.center_x;
            REG_CENTER_Y: prdata = cfg_reg.center_y;
            REG_CENTER_Z: prdata = cfg_reg.center_z;
            REG_SIZE_X:   prdata = {1'b0, cfg_reg.size_x};
            REG_SIZE_Y:   prdata = {1'b0, cfg_reg.size_y};
            REG_SIZE_Z:   prdata = {1'b0, cfg_reg.size_z};
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/iba_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bound accumulator front end
// Three-stage pipeline mapping a matrix row to a saturated interval.
// ----------------------------------------------------------------------------
module iba_front
    import iba_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire mesh_cfg_t cfg,
    iba_in_if.sink     in_ch,
    output logic       push,
    output span_t      push_data,
    input  wire logic  q_ready
);

    // Stage valid bits.
    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic s1_ready, s2_ready, s3_ready;

    // Stage 1: products.
    logic [1:0]         s1_axis_reg;
    logic               s1_first_reg;
    logic signed [31:0] s1_t_reg;
    logic signed [63:0] s1_pc_x_reg, s1_pc_y_reg, s1_pc_z_reg;
    logic [62:0]        s1_pe_x_reg, s1_pe_y_reg, s1_pe_z_reg;
    logic [31:0]        abs_x, abs_y, abs_z;

    // Stage 2: centre and half extent.
    logic [1:0]         s2_axis_reg;
    logic               s2_first_reg;
    logic signed [49:0] s2_centre_reg, s2_centre_next;
    logic [46:0]        s2_half_reg, s2_half_next;
    logic [63:0]        ext_sum;

    // Stage 3: saturated interval.
    span_t              s3_span_reg, s3_span_next;
    logic signed [50:0] lo_wide, hi_wide;

    assign s3_ready    = !s3_v_reg || q_ready;
    assign s2_ready    = !s2_v_reg || s3_ready;
    assign s1_ready    = !s1_v_reg || s2_ready;
    assign in_ch.ready = s1_ready;
    assign push        = s3_v_reg;
    assign push_data   = s3_span_reg;

    // Magnitudes of the rotation/scale entries.
    assign abs_x = in_ch.row_x[31] ? (~in_ch.row_x + 32'd1) : in_ch.row_x;
    assign abs_y = in_ch.row_y[31] ? (~in_ch.row_y + 32'd1) : in_ch.row_y;
    assign abs_z = in_ch.row_z[31] ? (~in_ch.row_z + 32'd1) : in_ch.row_z;

    // Centre sum with each product floored to Q16.16, and the halved extent.
    assign s2_centre_next = 50'($signed(s1_pc_x_reg[63:Q_FRAC]))
                          + 50'($signed(s1_pc_y_reg[63:Q_FRAC]))
                          + 50'($signed(s1_pc_z_reg[63:Q_FRAC]))
                          + 50'(s1_t_reg);
    assign ext_sum      = 64'(s1_pe_x_reg) + 64'(s1_pe_y_reg) + 64'(s1_pe_z_reg);
    assign s2_half_next = ext_sum[63:Q_FRAC + 1];

    // Interval ends, clamped to the Q16.16 range.
    assign lo_wide = 51'(s2_centre_reg) - 51'($signed({1'b0, s2_half_reg}));
    assign hi_wide = 51'(s2_centre_reg) + 51'($signed({1'b0, s2_half_reg}));

    always_comb
    begin
        s3_span_next.axis  = s2_axis_reg;
        s3_span_next.first = s2_first_reg;
        s3_span_next.lo    = sat_q(lo_wide);
        s3_span_next.hi    = sat_q(hi_wide);
    end

    // Valid bits advance whenever the next stage can take the word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_v_reg <= in_ch.valid;
            end
            if (s2_ready)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_ready)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    // Payload registers load only with a valid word moving in.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && s1_ready)
        begin
            s1_axis_reg  <= in_ch.axis;
            s1_first_reg <= in_ch.first;
            s1_t_reg     <= in_ch.row_t;
            s1_pc_x_reg  <= in_ch.row_x * cfg.center_x;
            s1_pc_y_reg  <= in_ch.row_y * cfg.center_y;
            s1_pc_z_reg  <= in_ch.row_z * cfg.center_z;
            s1_pe_x_reg  <= 63'(abs_x) * 63'(cfg.size_x);
            s1_pe_y_reg  <= 63'(abs_y) * 63'(cfg.size_y);
            s1_pe_z_reg  <= 63'(abs_z) * 63'(cfg.size_z);
        end
        if (s1_v_reg && s2_ready)
        begin
            s2_axis_reg   <= s1_axis_reg;
            s2_first_reg  <= s1_first_reg;
            s2_centre_reg <= s2_centre_next;
            s2_half_reg   <= s2_half_next;
        end
        if (s2_v_reg && s3_ready)
        begin
            s3_span_reg <= s3_span_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/iba_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bound accumulator queue
// Small FIFO of intervals between the front end and the merge stage.
// ----------------------------------------------------------------------------
module iba_queue
    import iba_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire span_t push_data,
    output logic       ready,
    input  wire logic  pop,
    output logic       valid,
    output span_t      pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    span_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign ready    = (count_reg != CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/iba_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bound accumulator merge stage
// Merges intervals into the running per-axis bounds and drives the output.
// ----------------------------------------------------------------------------
module iba_back
    import iba_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  wire span_t q_data,
    output logic       pop,
    iba_out_if.source  out_ch
);

    logic signed [31:0] min_reg [3];
    logic signed [31:0] max_reg [3];
    logic signed [31:0] cur_min, cur_max;
    logic signed [31:0] new_min, new_max;
    logic               axis_ok;

    logic               out_v_reg, out_v_next;
    logic [1:0]         out_axis_reg;
    logic signed [31:0] out_lo_reg, out_hi_reg;

    assign pop = q_valid && (!out_v_reg || out_ch.ready);

    // Current bounds of the word's axis.
    always_comb
    begin
        axis_ok = 1'b1;
        case (q_data.axis)
            AXIS_X:
            begin
                cur_min = min_reg[0];
                cur_max = max_reg[0];
            end
            AXIS_Y:
            begin
                cur_min = min_reg[1];
                cur_max = max_reg[1];
            end
            AXIS_Z:
            begin
                cur_min = min_reg[2];
                cur_max = max_reg[2];
            end
            default:
            begin
                axis_ok = 1'b0;
                cur_min = '0;
                cur_max = '0;
            end
        endcase
    end

    // Restart or widen the bounds; an invalid axis reports zeros.
    always_comb
    begin
        if (!axis_ok)
        begin
            new_min = '0;
            new_max = '0;
        end
        else if (q_data.first)
        begin
            new_min = q_data.lo;
            new_max = q_data.hi;
        end
        else
        begin
            new_min = ($signed(q_data.lo) < cur_min) ? q_data.lo : cur_min;
            new_max = ($signed(q_data.hi) > cur_max) ? q_data.hi : cur_max;
        end
    end

    assign out_v_next = pop ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= Q_MAX;
                max_reg[i] <= Q_MIN;
            end
        end
        else
        begin
            out_v_reg <= out_v_next;
            if (pop && axis_ok)
            begin
                min_reg[q_data.axis] <= new_min;
                max_reg[q_data.axis] <= new_max;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_axis_reg <= q_data.axis;
            out_lo_reg   <= new_min;
            out_hi_reg   <= new_max;
        end
    end

    assign out_ch.valid      = out_v_reg;
    assign out_ch.out_axis   = out_axis_reg;
    assign out_ch.low_bound  = out_lo_reg;
    assign out_ch.high_bound = out_hi_reg;

endmodule
`default_nettype wire

/* rtl/core/instance_bound_accumulator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bound accumulator core
// Running axis-aligned bounds of a mesh instanced under streamed transforms.
// ----------------------------------------------------------------------------
// Usage:
// Program the mesh bound centre and full size over the APB port while idle.
// Each word on in_ch is one row of an instance transform for one axis; the
// core maps the mesh bound through that row, saturates the interval to
// Q16.16 and merges it into that axis's running minimum and maximum. A word
// with first set restarts the axis. Every input word yields one word on
// out_ch carrying the axis and its updated bounds.
// Throughput is one word per clock while out_ch does not stall. A word
// passes three front stages (products, sums, saturation), the queue and
// the output register of the merge stage. The merge reads the per-axis
// bounds combinationally and writes them back on the pop, so consecutive
// words on the same axis follow back to back. When out_ch stalls, the
// output register holds and the queue fills; the front end keeps working
// until the queue and its own stages are full and then deasserts
// in_ch.ready. Reset empties the pipeline and queue, clears the registers
// to zero and sets every axis to the empty bound (low above high).
// ----------------------------------------------------------------------------
module instance_bound_accumulator_core
    import iba_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    iba_in_if.sink           in_ch,
    iba_out_if.source        out_ch
);

    mesh_cfg_t cfg;
    logic      push, q_ready, q_valid, pop;
    span_t     push_data, q_data;

    // Configuration registers.
    iba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Row to interval pipeline.
    iba_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_ch     (in_ch),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready)
    );

    // Decoupling queue.
    iba_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (q_ready),
        .pop       (pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    // Bound merge and output.
    iba_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
`default_nettype wire

/* dv/tb_instance_bound_accumulator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Instance bound accumulator testbench
// Streams matrix rows into the core and checks every bounds word on the
// output. A directed list covers reset behavior, saturation, the unused
// axis code and restarts. Random phases follow, each with its own mesh
// setting. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_instance_bound_accumulator_core;
    import iba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_WORDS    = 150;
    localparam int PHASE_COUNT    = 7;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = 20;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    // One matrix row as it travels on the input channel.
    typedef struct packed {
        logic [1:0]         axis;
        logic               first;
        logic signed [31:0] row_x;
        logic signed [31:0] row_y;
        logic signed [31:0] row_z;
        logic signed [31:0] row_t;
    } row_word_t;

    // One bounds word as it travels on the output channel.
    typedef struct packed {
        logic [1:0]         out_axis;
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
    } bounds_word_t;

    typedef enum logic [1:0] {ROW_WORD, ROW_CHECKED, ROW_REG} row_kind_t;
    typedef enum int {ENTRY_MODERATE, ENTRY_FULL, ENTRY_EXTREME} entry_mode_t;

    // One line of the directed list.
    typedef struct packed {
        row_kind_t    kind;
        row_word_t    word;
        bounds_word_t typed;
        logic [2:0]   reg_idx;
        logic [31:0]  reg_val;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    iba_in_if  in_ch ();
    iba_out_if out_ch ();

    // Mesh bound shadow and running bounds per axis.
    logic signed [63:0] mesh_center [3];
    logic [63:0]        mesh_size [3];
    logic signed [31:0] axis_low [3];
    logic signed [31:0] axis_high [3];

    bounds_word_t  expected_bounds [$];
    directed_row_t directed_rows [$];

    int fault_count    = 0;
    int cycle_count    = 0;
    int src_quiet_left = 0;
    bit calm           = 1'b0;

    instance_bound_accumulator_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Clamp a wide value into the Q16.16 range.
    function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v);
        if (v > Q_MAX)
        begin
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // Map the mesh bound through one row and merge it into the axis bounds.
    function automatic bounds_word_t merge_row(input row_word_t w);
        logic signed [63:0] rows [3];
        logic signed [63:0] centre;
        logic signed [63:0] half;
        logic [63:0]        extent;
        logic [63:0]        mag;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        bounds_word_t       b;
        b.out_axis = w.axis;
        if (w.axis == AXIS_NONE)
        begin
            b.low_bound  = '0;
            b.high_bound = '0;
            return b;
        end
        rows[0] = w.row_x;
        rows[1] = w.row_y;
        rows[2] = w.row_z;
        centre  = w.row_t;
        extent  = '0;
        for (int j = 0; j < 3; j++)
        begin
            // Each centre product rounds toward minus infinity on its own.
            centre = centre + ((rows[j] * mesh_center[j]) >>> Q_FRAC);
            mag    = (rows[j] < 0) ? -rows[j] : rows[j];
            extent = extent + mag * mesh_size[j];
        end
        // Halving and rescaling are one shift of the full extent sum.
        half = $signed(extent >> (Q_FRAC + 1));
        lo   = clamp_q(centre - half);
        hi   = clamp_q(centre + half);
        if (w.first)
        begin
            axis_low[w.axis]  = lo;
            axis_high[w.axis] = hi;
        end
        else
        begin
            if (lo < axis_low[w.axis])
            begin
                axis_low[w.axis] = lo;
            end
            if (hi > axis_high[w.axis])
            begin
                axis_high[w.axis] = hi;
            end
        end
        b.low_bound  = axis_low[w.axis];
        b.high_bound = axis_high[w.axis];
        return b;
    endfunction

    // Directed list builders.
    function automatic directed_row_t word_row(input logic [1:0] axis, input logic first,
                                               input logic signed [31:0] rx,
                                               input logic signed [31:0] ry,
                                               input logic signed [31:0] rz,
                                               input logic signed [31:0] rt);
        directed_row_t d;
        d      = '0;
        d.kind = ROW_WORD;
        d.word = '{axis: axis, first: first, row_x: rx, row_y: ry, row_z: rz, row_t: rt};
        return d;
    endfunction

    function automatic directed_row_t checked_row(input logic [1:0] axis, input logic first,
                                                  input logic signed [31:0] rx,
                                                  input logic signed [31:0] ry,
                                                  input logic signed [31:0] rz,
                                                  input logic signed [31:0] rt,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
        directed_row_t d;
        d       = word_row(axis, first, rx, ry, rz, rt);
        d.kind  = ROW_CHECKED;
        d.typed = '{out_axis: axis, low_bound: lo, high_bound: hi};
        return d;
    endfunction

    function automatic directed_row_t reg_row(input logic [2:0] idx, input logic [31:0] val);
        directed_row_t d;
        d         = '0;
        d.kind    = ROW_REG;
        d.reg_idx = idx;
        d.reg_val = val;
        return d;
    endfunction

    // One random matrix entry of the given flavor.
    function automatic logic signed [31:0] random_entry(input entry_mode_t mode,
                                                        input int unsigned span);
        logic signed [31:0] v;
        case (mode)
            ENTRY_FULL:
            begin
                v = $urandom;
            end
            ENTRY_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0: v = Q_MIN;
                    1: v = Q_MAX;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 2 * span);
                v = v - span;
            end
        endcase
        return v;
    endfunction

    // Rows of instance sets: mostly moderate values, some full width and extremes.
    function automatic row_word_t random_word();
        row_word_t   w;
        entry_mode_t mode;
        int          pick;
        pick = $urandom_range(0, 9);
        mode = (pick < 7) ? ENTRY_MODERATE : (pick < 9) ? ENTRY_FULL : ENTRY_EXTREME;
        w.axis  = ($urandom_range(0, 15) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
        w.first = ($urandom_range(0, 7) == 0);
        w.row_x = random_entry(mode, 32'h0004_0000);
        w.row_y = random_entry(mode, 32'h0004_0000);
        w.row_z = random_entry(mode, 32'h0004_0000);
        w.row_t = random_entry(mode, 32'h0100_0000);
        return w;
    endfunction

    task automatic note_fault(input string msg);
        if (fault_count < REPORT_LIMIT)
        begin
            $display("%s", msg);
        end
        fault_count++;
    endtask

    // Present one word, with an occasional idle burst first, until accepted.
    task automatic send_word(input row_word_t w);
        int gap;
        @(negedge clk);
        gap = 0;
        if (!calm)
        begin
            if (src_quiet_left > 0)
            begin
                src_quiet_left--;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                src_quiet_left = $urandom_range(20, 80);
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 10);
            end
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.axis  <= w.axis;
        in_ch.first <= w.first;
        in_ch.row_x <= w.row_x;
        in_ch.row_y <= w.row_y;
        in_ch.row_z <= w.row_z;
        in_ch.row_t <= w.row_t;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Write one register once the core has returned every pending word.
    task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_bounds.size() != 0) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < REG_SIZE_X)
        begin
            mesh_center[idx] = {{32{val[31]}}, val};
        end
        else
        begin
            mesh_size[idx - REG_SIZE_X] = {33'd0, val[30:0]};
        end
    endtask

    // Output ready: random stall bursts, quiet stretches, none when calm.
    initial
    begin
        int stall_left;
        int quiet_left;
        stall_left   = 0;
        quiet_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                out_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (quiet_left > 0)
                begin
                    quiet_left--;
                end
                else if ($urandom_range(0, 39) == 0)
                begin
                    quiet_left = $urandom_range(20, 80);
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(1, 10);
                end
            end
        end
    end

    // Compare each returned word with the oldest expectation.
    always @(posedge clk)
    begin : check_bounds
        bounds_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_bounds.size() == 0)
            begin
                note_fault($sformatf("unexpected word: axis %0d [%0d, %0d]",
                                     out_ch.out_axis, out_ch.low_bound, out_ch.high_bound));
            end
            else
            begin
                want = expected_bounds.pop_front();
                if (out_ch.out_axis !== want.out_axis || out_ch.low_bound !== want.low_bound
                    || out_ch.high_bound !== want.high_bound)
                begin
                    note_fault($sformatf(
                        "bounds mismatch: expected axis %0d [%0d, %0d], got axis %0d [%0d, %0d]",
                        want.out_axis, want.low_bound, want.high_bound,
                        out_ch.out_axis, out_ch.low_bound, out_ch.high_bound));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0]  phase_regs [6];
        bounds_word_t predicted;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_ch.valid = 1'b0;
        in_ch.axis  = AXIS_X;
        in_ch.first = 1'b0;
        in_ch.row_x = '0;
        in_ch.row_y = '0;
        in_ch.row_z = '0;
        in_ch.row_t = '0;
        for (int a = 0; a < 3; a++)
        begin
            mesh_center[a] = '0;
            mesh_size[a]   = '0;
            axis_low[a]    = Q_MAX;
            axis_high[a]   = Q_MIN;
        end

        // With the reset setting every interval collapses onto row_t, and an
        // untouched axis is empty, so its first merge takes the interval as is.
        directed_rows.push_back(checked_row(AXIS_X, 1'b0, 0, 0, 0, ONE, ONE, ONE));
        directed_rows.push_back(checked_row(AXIS_X, 1'b0, 0, 0, 0, Q_MAX, ONE, Q_MAX));
        directed_rows.push_back(checked_row(AXIS_X, 1'b0, 0, 0, 0, Q_MIN, Q_MIN, Q_MAX));
        directed_rows.push_back(checked_row(AXIS_X, 1'b1, 0, 0, 0, -ONE / 2, -ONE / 2, -ONE / 2));
        directed_rows.push_back(checked_row(AXIS_Y, 1'b1, Q_MIN, Q_MAX, -1, Q_MIN, Q_MIN, Q_MIN));
        directed_rows.push_back(checked_row(AXIS_Z, 1'b0, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0));
        // The unused axis code leaves every axis alone and returns zeros.
        directed_rows.push_back(checked_row(AXIS_NONE, 1'b1, -1, -1, -1, Q_MAX, 0, 0));
        directed_rows.push_back(checked_row(AXIS_NONE, 1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 0, 0));
        directed_rows.push_back(checked_row(AXIS_Z, 1'b0, 0, 0, 0, 5, 0, 5));
        directed_rows.push_back(checked_row(AXIS_Y, 1'b0, 0, 0, 0, 0, Q_MIN, 0));
        // Extreme mesh: products far outside the range saturate both ends.
        directed_rows.push_back(reg_row(REG_CENTER_X, Q_MAX));
        directed_rows.push_back(reg_row(REG_CENTER_Y, Q_MIN));
        directed_rows.push_back(reg_row(REG_CENTER_Z, ONE));
        directed_rows.push_back(reg_row(REG_SIZE_X, 32'h7FFF_FFFF));
        directed_rows.push_back(reg_row(REG_SIZE_Y, 32'h7FFF_FFFF));
        directed_rows.push_back(reg_row(REG_SIZE_Z, 2 * ONE));
        directed_rows.push_back(checked_row(AXIS_X, 1'b1, Q_MAX, 0, 0, 0, Q_MAX, Q_MAX));
        directed_rows.push_back(checked_row(AXIS_X, 1'b0, Q_MIN, 0, 0, 0, Q_MIN, Q_MAX));
        directed_rows.push_back(checked_row(AXIS_Y, 1'b1, 0, Q_MIN, 0, 0, Q_MAX, Q_MAX));
        directed_rows.push_back(checked_row(AXIS_Z, 1'b1, 0, 0, ONE, 0, 0, 2 * ONE));
        directed_rows.push_back(checked_row(AXIS_Z, 1'b0, 0, 0, -ONE, ONE, -ONE, 2 * ONE));
        directed_rows.push_back(checked_row(AXIS_X, 1'b1, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN));
        // Rounding of tiny and negative products.
        directed_rows.push_back(word_row(AXIS_X, 1'b1, -1, 1, 1, 0));
        directed_rows.push_back(word_row(AXIS_Y, 1'b1, 3, -3, -5, Q_MAX));
        directed_rows.push_back(reg_row(REG_CENTER_X, -(ONE + ONE / 2)));
        directed_rows.push_back(reg_row(REG_CENTER_Y, 3 * ONE));
        directed_rows.push_back(reg_row(REG_CENTER_Z, Q_MIN));
        directed_rows.push_back(reg_row(REG_SIZE_X, 32'h0000_0000));
        directed_rows.push_back(reg_row(REG_SIZE_Y, ONE));
        directed_rows.push_back(reg_row(REG_SIZE_Z, ONE / 2));
        directed_rows.push_back(word_row(AXIS_X, 1'b1, ONE / 2, -ONE, 0, ONE));
        directed_rows.push_back(word_row(AXIS_Z, 1'b0, 0, 0, Q_MAX, 0));
        directed_rows.push_back(word_row(AXIS_Y, 1'b0, -7, 13, 1, -3));
        directed_rows.push_back(word_row(AXIS_Z, 1'b1, 1, -1, -1, -ONE));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed list.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                program_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
            begin
                send_word(directed_rows[i].word);
                predicted = merge_row(directed_rows[i].word);
                if (directed_rows[i].kind == ROW_CHECKED)
                begin
                    expected_bounds.push_back(directed_rows[i].typed);
                end
                else
                begin
                    expected_bounds.push_back(predicted);
                end
            end
        end

        // Random phases, each under a fresh mesh setting.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            for (int r = REG_CENTER_X; r <= REG_SIZE_Z; r++)
            begin
                case (phase)
                    1:       phase_regs[r] = (r < REG_SIZE_X) ? Q_MAX : 32'h7FFF_FFFF;
                    2:       phase_regs[r] = (r < REG_SIZE_X) ? Q_MIN : 32'h0000_0000;
                    3:       phase_regs[r] = (r < REG_SIZE_X) ? $urandom : $urandom >> 1;
                    default:
                    begin
                        phase_regs[r] = $urandom_range(0, 32'h0200_0000);
                        if (r < REG_SIZE_X)
                        begin
                            phase_regs[r] = phase_regs[r] - 32'h0100_0000;
                        end
                    end
                endcase
                program_reg(r[2:0], phase_regs[r]);
            end
            calm = (phase == PHASE_COUNT - 1);
            repeat (PHASE_WORDS)
            begin
                row_word_t w;
                w = random_word();
                send_word(w);
                expected_bounds.push_back(merge_row(w));
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_bounds.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/iba_pkg.sv
rtl/core/iba_if.sv
rtl/core/iba_regs.sv
rtl/core/iba_front.sv
rtl/core/iba_queue.sv
rtl/core/iba_back.sv
rtl/core/instance_bound_accumulator_core.sv
dv/tb_instance_bound_accumulator_core.sv
